>>> hw/rtl/gray_glyph_rasterizer_assert.svh
// ---------------------------------------------------------------------------
// gray_glyph_rasterizer assertion macros
// shared property forms for the rasterizer checks
// ---------------------------------------------------------------------------
`ifndef GRAY_GLYPH_RASTERIZER_ASSERT_SVH
`define GRAY_GLYPH_RASTERIZER_ASSERT_SVH

// same-cycle implication, disabled during reset
`define GGR_ASSERT_IMPLY(label, clk, rst_n, a, b) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (b)) \
        else $error("rasterizer check failed");

// next-cycle implication, disabled during reset
`define GGR_ASSERT_NEXT(label, clk, rst_n, a, b) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (b)) \
        else $error("rasterizer check failed");

`endif

>>> hw/rtl/ggr_pkg.sv
// ---------------------------------------------------------------------------
// ggr_pkg
// types, codes and constants shared by the glyph rasterizer files
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

package ggr_pkg;

    // default storage and glyph limits
    localparam int unsigned DEF_GLYPH_SLOTS  = 128;
    localparam int unsigned DEF_BITMAP_BYTES = 4096;
    localparam int unsigned DEF_MAX_WIDTH    = 8;
    localparam int unsigned DEF_MAX_HEIGHT   = 16;

    // pixels per result group
    localparam int unsigned LANES = 4;

    // configuration port
    localparam int unsigned CFG_ADDR_W = 5;
    localparam int unsigned CFG_DATA_W = 32;

    // register indexes
    localparam logic [2:0] REG_SHADE_BG    = 3'd0;
    localparam logic [2:0] REG_SHADE_DARK  = 3'd1;
    localparam logic [2:0] REG_SHADE_LIGHT = 3'd2;
    localparam logic [2:0] REG_SHADE_FG    = 3'd3;
    localparam logic [2:0] REG_FIRST_CODE  = 3'd4;
    localparam logic [2:0] REG_GLYPH_COUNT = 3'd5;
    localparam logic [2:0] REG_ABSENT_CODE = 3'd6;
    localparam logic [2:0] REG_FONT_HEIGHT = 3'd7;

    // register reset values
    localparam logic [15:0] RST_SHADE_BG    = 16'd0;
    localparam logic [15:0] RST_SHADE_DARK  = 16'd21162;
    localparam logic [15:0] RST_SHADE_LIGHT = 16'd44373;
    localparam logic [15:0] RST_SHADE_FG    = 16'd65535;
    localparam logic [7:0]  RST_FIRST_CODE  = 8'd32;
    localparam logic [7:0]  RST_GLYPH_COUNT = 8'd95;
    localparam logic [7:0]  RST_ABSENT_CODE = 8'd63;
    localparam logic [4:0]  RST_FONT_HEIGHT = 5'd16;

    // request type codes
    localparam logic [1:0] REQ_RENDER = 2'd0;
    localparam logic [1:0] REQ_DESC   = 2'd1;
    localparam logic [1:0] REQ_BYTE   = 2'd2;

    // configuration register bank
    typedef struct packed {
        logic [3:0][15:0] shade;
        logic [7:0]       first_code;
        logic [7:0]       glyph_count;
        logic [7:0]       absent_code;
        logic [4:0]       font_height;
    } cfg_t;

    // glyph descriptor, 27 bits
    typedef struct packed {
        logic [13:0] offset;
        logic [4:0]  rows;
        logic [3:0]  lift;
        logic [3:0]  width;
    } desc_t;

    // controller state
    typedef enum logic [1:0] {
        ST_IDLE,
        ST_FETCH,
        ST_SETUP,
        ST_EMIT
    } state_t;

    // controller to datapath commands
    typedef struct packed {
        logic capture;
        logic write_desc;
        logic write_byte;
        logic setup;
        logic emit;
    } ctrl_cmd_t;

    // datapath to controller status
    typedef struct packed {
        logic out_free;
        logic group_last;
    } dp_status_t;

endpackage

>>> hw/rtl/ggr_req_if.sv
// ---------------------------------------------------------------------------
// ggr_req_if
// request channel: render and load transactions
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

interface ggr_req_if;
    logic        valid;
    logic        ready;
    logic [1:0]  req_type;
    logic [7:0]  char_code;
    logic [6:0]  slot_index;
    logic [3:0]  glyph_width;
    logic [3:0]  glyph_lift;
    logic [4:0]  glyph_rows;
    logic [13:0] data_offset;
    logic [11:0] byte_address;
    logic [7:0]  byte_value;

    modport source (
        output valid, req_type, char_code, slot_index, glyph_width, glyph_lift,
               glyph_rows, data_offset, byte_address, byte_value,
        input  ready
    );

    modport sink (
        input  valid, req_type, char_code, slot_index, glyph_width, glyph_lift,
               glyph_rows, data_offset, byte_address, byte_value,
        output ready
    );
endinterface

>>> hw/rtl/ggr_res_if.sv
// ---------------------------------------------------------------------------
// ggr_res_if
// result channel: one group of four pixels per transaction
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

interface ggr_res_if;
    logic        valid;
    logic        ready;
    logic [15:0] pixel_a;
    logic [15:0] pixel_b;
    logic [15:0] pixel_c;
    logic [15:0] pixel_d;
    logic [2:0]  pixel_valid;
    logic [3:0]  advance;
    logic        last_group;

    modport source (
        output valid, pixel_a, pixel_b, pixel_c, pixel_d, pixel_valid, advance,
               last_group,
        input  ready
    );

    modport sink (
        input  valid, pixel_a, pixel_b, pixel_c, pixel_d, pixel_valid, advance,
               last_group,
        output ready
    );
endinterface

>>> hw/rtl/ggr_regs.sv
// ---------------------------------------------------------------------------
// ggr_regs
// apb register bank for shades, code range and font height
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module ggr_regs (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               psel,
    input  logic                               penable,
    input  logic                               pwrite,
    input  logic [ggr_pkg::CFG_ADDR_W-1:0]     paddr,
    input  logic [ggr_pkg::CFG_DATA_W-1:0]     pwdata,
    output logic [ggr_pkg::CFG_DATA_W-1:0]     prdata,
    output logic                               pready,
    output ggr_pkg::cfg_t                      cfg
);
    import ggr_pkg::*;

    cfg_t       cfg_reg;
    logic [2:0] reg_idx;
    logic       wr_en;

    assign reg_idx = paddr[4:2];
    assign wr_en   = psel && penable && pwrite;
    assign pready  = 1'b1;
    assign cfg     = cfg_reg;

    // register writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.shade[0]    <= RST_SHADE_BG;
            cfg_reg.shade[1]    <= RST_SHADE_DARK;
            cfg_reg.shade[2]    <= RST_SHADE_LIGHT;
            cfg_reg.shade[3]    <= RST_SHADE_FG;
            cfg_reg.first_code  <= RST_FIRST_CODE;
            cfg_reg.glyph_count <= RST_GLYPH_COUNT;
            cfg_reg.absent_code <= RST_ABSENT_CODE;
            cfg_reg.font_height <= RST_FONT_HEIGHT;
        end
        else if (wr_en)
        begin
            case (reg_idx)
                REG_SHADE_BG:    cfg_reg.shade[0]    <= pwdata[15:0];
                REG_SHADE_DARK:  cfg_reg.shade[1]    <= pwdata[15:0];
                REG_SHADE_LIGHT: cfg_reg.shade[2]    <= pwdata[15:0];
                REG_SHADE_FG:    cfg_reg.shade[3]    <= pwdata[15:0];
                REG_FIRST_CODE:  cfg_reg.first_code  <= pwdata[7:0];
                REG_GLYPH_COUNT: cfg_reg.glyph_count <= pwdata[7:0];
                REG_ABSENT_CODE: cfg_reg.absent_code <= pwdata[7:0];
                REG_FONT_HEIGHT: cfg_reg.font_height <= pwdata[4:0];
                default:         cfg_reg             <= cfg_reg;
            endcase
        end
    end

    // read mux
    always_comb
    begin
        case (reg_idx)
            REG_SHADE_BG:    prdata = CFG_DATA_W'(cfg_reg.shade[0]);
            REG_SHADE_DARK:  prdata = CFG_DATA_W'(cfg_reg.shade[1]);
            REG_SHADE_LIGHT: prdata = CFG_DATA_W'(cfg_reg.shade[2]);
            REG_SHADE_FG:    prdata = CFG_DATA_W'(cfg_reg.shade[3]);
            REG_FIRST_CODE:  prdata = CFG_DATA_W'(cfg_reg.first_code);
            REG_GLYPH_COUNT: prdata = CFG_DATA_W'(cfg_reg.glyph_count);
            REG_ABSENT_CODE: prdata = CFG_DATA_W'(cfg_reg.absent_code);
            REG_FONT_HEIGHT: prdata = CFG_DATA_W'(cfg_reg.font_height);
            default:         prdata = '0;
        endcase
    end

endmodule

>>> hw/rtl/ggr_ctrl.sv
// ---------------------------------------------------------------------------
// ggr_ctrl
// sequencer: request intake, descriptor fetch, setup and group emission
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module ggr_ctrl (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                req_valid,
    input  logic [1:0]          req_type,
    input  ggr_pkg::dp_status_t status,
    output logic                req_ready,
    output ggr_pkg::ctrl_cmd_t  cmd
);
    import ggr_pkg::*;

    state_t state_reg;
    state_t state_next;

    // state register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (req_valid && req_type == REQ_RENDER)
                begin
                    state_next = ST_FETCH;
                end
            end
            ST_FETCH: state_next = ST_SETUP;
            ST_SETUP: state_next = ST_EMIT;
            ST_EMIT:
            begin
                if (status.out_free && status.group_last)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:  state_next = ST_IDLE;
        endcase
    end

    // outputs
    always_comb
    begin
        req_ready      = 1'b0;
        cmd            = '0;
        case (state_reg)
            ST_IDLE:
            begin
                req_ready      = 1'b1;
                cmd.capture    = req_valid && req_type == REQ_RENDER;
                cmd.write_desc = req_valid && req_type == REQ_DESC;
                cmd.write_byte = req_valid && req_type == REQ_BYTE;
            end
            ST_FETCH: cmd = '0;
            ST_SETUP: cmd.setup = 1'b1;
            ST_EMIT:  cmd.emit  = status.out_free;
            default:  cmd = '0;
        endcase
    end

endmodule

>>> hw/rtl/ggr_datapath.sv
// ---------------------------------------------------------------------------
// ggr_datapath
// glyph table, bitmap store, four-lane pixel unit and output register
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "gray_glyph_rasterizer_assert.svh"

module ggr_datapath #(
    parameter int unsigned GLYPH_SLOTS  = ggr_pkg::DEF_GLYPH_SLOTS,
    parameter int unsigned BITMAP_BYTES = ggr_pkg::DEF_BITMAP_BYTES,
    parameter int unsigned MAX_WIDTH    = ggr_pkg::DEF_MAX_WIDTH,
    parameter int unsigned MAX_HEIGHT   = ggr_pkg::DEF_MAX_HEIGHT
) (
    input  logic                clk,
    input  logic                rst_n,
    input  ggr_pkg::cfg_t       cfg,
    input  ggr_pkg::ctrl_cmd_t  cmd,
    output ggr_pkg::dp_status_t status,
    input  logic [7:0]          char_code,
    input  logic [6:0]          slot_index,
    input  logic [3:0]          glyph_width,
    input  logic [3:0]          glyph_lift,
    input  logic [4:0]          glyph_rows,
    input  logic [13:0]         data_offset,
    input  logic [11:0]         byte_address,
    input  logic [7:0]          byte_value,
    output logic                out_valid,
    input  logic                out_ready,
    output logic [15:0]         pixel_a,
    output logic [15:0]         pixel_b,
    output logic [15:0]         pixel_c,
    output logic [15:0]         pixel_d,
    output logic [2:0]          pixel_valid,
    output logic [3:0]          advance,
    output logic                last_group
);
    import ggr_pkg::*;

    localparam int unsigned SLOT_W = (GLYPH_SLOTS > 1) ? $clog2(GLYPH_SLOTS) : 1;
    localparam int unsigned BA_W   = $clog2(BITMAP_BYTES);
    localparam int unsigned SREM_W = 17;
    localparam int unsigned BREM_W = 25;
    localparam logic [SREM_W-1:0] SLOTS_C = SREM_W'(GLYPH_SLOTS);
    localparam logic [BREM_W-1:0] BYTES_C = BREM_W'(BITMAP_BYTES);
    localparam logic [BA_W-1:0]   ADDR_LAST = BA_W'(BITMAP_BYTES - 1);

    // storage
    desc_t      glyph_table [GLYPH_SLOTS];
    logic [7:0] bitmap_store [BITMAP_BYTES];

    // render context
    logic [7:0]      code_reg;
    desc_t           ent_reg;
    logic [3:0]      w_reg;
    logic [3:0]      lift_reg;
    logic [4:0]      rows_reg;
    logic [4:0]      h_reg;
    logic [1:0]      pos_reg;
    logic [BA_W-1:0] addr_reg;
    logic [BA_W-1:0] addr_next;
    logic [BA_W-1:0] addr_next_p1;
    logic [BA_W-1:0] addr_inc;
    logic [4:0]      col_reg;
    logic [4:0]      row_reg;
    logic [7:0]      rd0_reg;
    logic [7:0]      rd1_reg;

    // output register
    logic        out_valid_reg;
    logic [15:0] pix_reg [LANES];
    logic [2:0]  cnt_reg;
    logic [3:0]  adv_reg;
    logic        last_reg;

    // slot selection
    logic [7:0]        code_off;
    logic [7:0]        absent_off;
    logic [7:0]        slot_raw;
    logic [SREM_W-1:0] slot_rem;
    logic [SLOT_W-1:0] slot_sel;

    // setup decode
    logic [BREM_W-1:0] addr_rem;
    logic [3:0]        w_sat;
    logic [4:0]        h_eff;

    // lane unit
    logic [4:0]  lane_col [LANES];
    logic [4:0]  lane_row [LANES];
    logic        lane_alive [LANES];
    logic        lane_last [LANES];
    logic        lane_ink [LANES];
    logic [15:0] lane_color [LANES];
    logic [2:0]  lane_pair;
    logic [1:0]  lane_val;
    logic [2:0]  ink_cnt;
    logic [2:0]  alive_cnt;
    logic        grp_last;
    logic [4:0]  h_last;
    logic [4:0]  w1;
    logic [5:0]  lift_end;
    logic [15:0] window;
    logic [2:0]  pair_sum;
    logic [4:0]  col_next;
    logic [4:0]  row_next;

    // code to slot, remainder by restoring subtraction
    always_comb
    begin
        code_off   = code_reg - cfg.first_code;
        absent_off = cfg.absent_code - cfg.first_code;
        if (code_reg < cfg.first_code || code_off >= cfg.glyph_count)
        begin
            slot_raw = absent_off;
        end
        else
        begin
            slot_raw = code_off;
        end
        slot_rem = SREM_W'(slot_raw);
        for (int k = 7; k >= 0; k--)
        begin
            if (slot_rem >= (SLOTS_C << k))
            begin
                slot_rem = slot_rem - (SLOTS_C << k);
            end
        end
        slot_sel = slot_rem[SLOT_W-1:0];
    end

    // glyph table port
    always_ff @(posedge clk)
    begin
        if (cmd.write_desc && SREM_W'(slot_index) < SLOTS_C)
        begin
            glyph_table[SLOT_W'(slot_index)] <= '{offset: data_offset, rows: glyph_rows,
                                                  lift: glyph_lift, width: glyph_width};
        end
        ent_reg <= glyph_table[slot_sel];
    end

    // descriptor decode: clamp width and height, wrap the start byte
    always_comb
    begin
        addr_rem = BREM_W'(ent_reg.offset[13:2]);
        for (int k = 7; k >= 0; k--)
        begin
            if (addr_rem >= (BYTES_C << k))
            begin
                addr_rem = addr_rem - (BYTES_C << k);
            end
        end
        if (7'(ent_reg.width) > 7'(MAX_WIDTH))
        begin
            w_sat = 4'(MAX_WIDTH);
        end
        else
        begin
            w_sat = ent_reg.width;
        end
        h_eff = (cfg.font_height == 5'd0) ? 5'd1 : cfg.font_height;
        if (7'(h_eff) > 7'(MAX_HEIGHT))
        begin
            h_eff = 5'(MAX_HEIGHT);
        end
    end

    // lane unit: four pixels in column-major order
    assign h_last   = h_reg - 5'd1;
    assign w1       = 5'(w_reg) + 5'd1;
    assign lift_end = 6'(lift_reg) + 6'(rows_reg);
    assign window   = {rd1_reg, rd0_reg};

    always_comb
    begin
        ink_cnt   = '0;
        alive_cnt = '0;
        grp_last  = 1'b0;
        lane_pair = '0;
        lane_val  = '0;
        for (int j = 0; j < LANES; j++)
        begin
            if (j == 0)
            begin
                lane_col[j]   = col_reg;
                lane_row[j]   = row_reg;
                lane_alive[j] = 1'b1;
            end
            else
            begin
                lane_alive[j] = lane_alive[j-1] && !lane_last[j-1];
                if (lane_row[j-1] == h_last)
                begin
                    lane_row[j] = '0;
                    lane_col[j] = lane_col[j-1] + 5'd1;
                end
                else
                begin
                    lane_row[j] = lane_row[j-1] + 5'd1;
                    lane_col[j] = lane_col[j-1];
                end
            end
            lane_last[j] = lane_col[j] == w1 && lane_row[j] == h_last;
            lane_ink[j]  = lane_alive[j] && lane_col[j] != 5'd0 && lane_col[j] != w1
                           && 6'(lane_row[j]) >= 6'(lift_reg) && 6'(lane_row[j]) < lift_end;
            lane_pair    = 3'(pos_reg) + ink_cnt;
            lane_val     = window[{lane_pair, 1'b0} +: 2];
            if (!lane_alive[j])
            begin
                lane_color[j] = '0;
            end
            else if (lane_ink[j])
            begin
                lane_color[j] = cfg.shade[lane_val];
            end
            else
            begin
                lane_color[j] = cfg.shade[0];
            end
            ink_cnt   = ink_cnt + 3'(lane_ink[j]);
            alive_cnt = alive_cnt + 3'(lane_alive[j]);
            grp_last  = grp_last || (lane_alive[j] && lane_last[j]);
        end
        pair_sum = 3'(pos_reg) + ink_cnt;
        if (lane_row[LANES-1] == h_last)
        begin
            row_next = '0;
            col_next = lane_col[LANES-1] + 5'd1;
        end
        else
        begin
            row_next = lane_row[LANES-1] + 5'd1;
            col_next = lane_col[LANES-1];
        end
    end

    // bitmap address; reads use the next address so data lines up with addr_reg
    always_comb
    begin
        addr_inc = (addr_reg == ADDR_LAST) ? '0 : addr_reg + 1'b1;
        if (cmd.setup)
        begin
            addr_next = addr_rem[BA_W-1:0];
        end
        else if (cmd.emit && pair_sum[2])
        begin
            addr_next = addr_inc;
        end
        else
        begin
            addr_next = addr_reg;
        end
        addr_next_p1 = (addr_next == ADDR_LAST) ? '0 : addr_next + 1'b1;
    end

    // bitmap store: one write port, two read ports
    always_ff @(posedge clk)
    begin
        if (cmd.write_byte && BREM_W'(byte_address) < BYTES_C)
        begin
            bitmap_store[BA_W'(byte_address)] <= byte_value;
        end
        rd0_reg <= bitmap_store[addr_next];
        rd1_reg <= bitmap_store[addr_next_p1];
    end

    // render context registers
    always_ff @(posedge clk)
    begin
        addr_reg <= addr_next;
        if (cmd.capture)
        begin
            code_reg <= char_code;
        end
        if (cmd.setup)
        begin
            w_reg    <= w_sat;
            lift_reg <= ent_reg.lift;
            rows_reg <= ent_reg.rows;
            h_reg    <= h_eff;
            pos_reg  <= ent_reg.offset[1:0];
            col_reg  <= '0;
            row_reg  <= '0;
        end
        else if (cmd.emit)
        begin
            pos_reg <= pair_sum[1:0];
            col_reg <= col_next;
            row_reg <= row_next;
        end
    end

    // output register valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (cmd.emit)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    // output register payload
    always_ff @(posedge clk)
    begin
        if (cmd.emit)
        begin
            for (int j = 0; j < LANES; j++)
            begin
                pix_reg[j] <= lane_color[j];
            end
            cnt_reg  <= alive_cnt;
            adv_reg  <= w_reg + 4'd1;
            last_reg <= grp_last;
        end
    end

    assign status.out_free   = !out_valid_reg || out_ready;
    assign status.group_last = grp_last;

    assign out_valid   = out_valid_reg;
    assign pixel_a     = pix_reg[0];
    assign pixel_b     = pix_reg[1];
    assign pixel_c     = pix_reg[2];
    assign pixel_d     = pix_reg[3];
    assign pixel_valid = cnt_reg;
    assign advance     = adv_reg;
    assign last_group  = last_reg;

    // checks
    `GGR_ASSERT_IMPLY(a_row_in_range, clk, rst_n, cmd.emit, row_reg < h_reg)
    `GGR_ASSERT_IMPLY(a_col_in_range, clk, rst_n, cmd.emit, col_reg <= w1)
    `GGR_ASSERT_IMPLY(a_addr_in_range, clk, rst_n, cmd.emit, BREM_W'(addr_reg) < BYTES_C)
    `GGR_ASSERT_IMPLY(a_full_group, clk, rst_n, out_valid_reg && !last_reg, cnt_reg == 3'(LANES))
    `GGR_ASSERT_NEXT(a_last_ends_render, clk, rst_n, cmd.emit && grp_last, !cmd.emit)

endmodule

>>> hw/rtl/gray_glyph_rasterizer.sv
// ---------------------------------------------------------------------------
// gray_glyph_rasterizer
// two-bit antialiased bitmap font renderer, top level
// ---------------------------------------------------------------------------
// req channel (valid/ready) takes one transaction per item: a descriptor
// write or bitmap byte write is taken while idle and yields nothing; a
// render transaction names a character code and yields a run of pixel
// groups on the res channel, four 16-bit pixels per transaction, the final
// one flagged by last_group and pixel_valid giving its used pixels.
// a render reads the descriptor table, then runs setup, then emits one
// group per cycle while res is not stalled, from the four-lane pixel unit
// fed by the two bitmap read ports. the first group is visible once the
// first emit cycle has loaded it into the output register.
// req is held off during a render; it opens again once the last group sits
// in the output register, even while that group waits to be taken.
// a stall on res holds the output register and freezes the pixel unit.
// reset clears the control state and loads the register defaults; the
// glyph table and bitmap store are not cleared and must be loaded first.
// shades, code range and font height sit on the apb port, written while idle.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module gray_glyph_rasterizer #(
    parameter int unsigned GLYPH_SLOTS  = ggr_pkg::DEF_GLYPH_SLOTS,
    parameter int unsigned BITMAP_BYTES = ggr_pkg::DEF_BITMAP_BYTES,
    parameter int unsigned MAX_WIDTH    = ggr_pkg::DEF_MAX_WIDTH,
    parameter int unsigned MAX_HEIGHT   = ggr_pkg::DEF_MAX_HEIGHT
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           psel,
    input  logic                           penable,
    input  logic                           pwrite,
    input  logic [ggr_pkg::CFG_ADDR_W-1:0] paddr,
    input  logic [ggr_pkg::CFG_DATA_W-1:0] pwdata,
    output logic [ggr_pkg::CFG_DATA_W-1:0] prdata,
    output logic                           pready,
    ggr_req_if.sink                        req,
    ggr_res_if.source                      res
);
    import ggr_pkg::*;

    cfg_t       cfg;
    ctrl_cmd_t  cmd;
    dp_status_t status;

    // configuration registers
    ggr_regs u_regs (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    // sequencer
    ggr_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req.valid),
        .req_type  (req.req_type),
        .status    (status),
        .req_ready (req.ready),
        .cmd       (cmd)
    );

    // storage and pixel datapath
    ggr_datapath #(
        .GLYPH_SLOTS  (GLYPH_SLOTS),
        .BITMAP_BYTES (BITMAP_BYTES),
        .MAX_WIDTH    (MAX_WIDTH),
        .MAX_HEIGHT   (MAX_HEIGHT)
    ) u_datapath (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg          (cfg),
        .cmd          (cmd),
        .status       (status),
        .char_code    (req.char_code),
        .slot_index   (req.slot_index),
        .glyph_width  (req.glyph_width),
        .glyph_lift   (req.glyph_lift),
        .glyph_rows   (req.glyph_rows),
        .data_offset  (req.data_offset),
        .byte_address (req.byte_address),
        .byte_value   (req.byte_value),
        .out_valid    (res.valid),
        .out_ready    (res.ready),
        .pixel_a      (res.pixel_a),
        .pixel_b      (res.pixel_b),
        .pixel_c      (res.pixel_c),
        .pixel_d      (res.pixel_d),
        .pixel_valid  (res.pixel_valid),
        .advance      (res.advance),
        .last_group   (res.last_group)
    );

endmodule
